// File: sv/timeline_change_point_table_macros.svh
// ---------------------------------------------------------------------------
// timeline change point table: assertion macros
// shared assertion wrappers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef TIMELINE_CHANGE_POINT_TABLE_MACROS_SVH
`define TIMELINE_CHANGE_POINT_TABLE_MACROS_SVH

`ifndef SYNTH
`define TCPT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCPT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: sv/tcpt_pkg.sv
// ---------------------------------------------------------------------------
// tcpt_pkg
// types, codes and widths of the timeline change point table
// ---------------------------------------------------------------------------
`default_nettype none

package tcpt_pkg;

  localparam int TCPT_TABLE_DEPTH = 16;
  localparam int TICK_W           = 32;
  localparam int TYPE_W           = 16;
  localparam int ACTION_W         = 2;
  localparam int STATUS_W         = 2;
  localparam int IN_FIELDS_W      = ACTION_W + TICK_W + TYPE_W;
  localparam int IN_DATA_W        = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W     = TYPE_W + 2 * TICK_W + STATUS_W;
  localparam int OUT_DATA_W       = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [TYPE_W-1:0] DEFAULT_TYPE_RST = '0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_SET    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_RANGE  = 2'd3
  } tcpt_action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_NEGATIVE  = 2'd3
  } tcpt_status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } tcpt_state_t;

  typedef struct packed {
    logic                     valid;
    logic signed [TICK_W-1:0] tick;
    logic        [TYPE_W-1:0] etype;
  } entry_t;

  typedef struct packed {
    logic                     insert;
    logic                     remove;
    logic                     overwrite;
    logic signed [TICK_W-1:0] new_tick;
    logic        [TYPE_W-1:0] new_type;
  } cell_cmd_t;

  typedef struct packed {
    logic le;
    logic lt;
    logic eq;
    logic floor_hit;
    logic ceil_hit;
  } cell_flags_t;

endpackage

`default_nettype wire

// File: sv/tcpt_cell.sv
// ---------------------------------------------------------------------------
// tcpt_cell
// one slot of the sorted change point chain, shifts with its neighbours
// ---------------------------------------------------------------------------
`default_nettype none

module tcpt_cell
  import tcpt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic signed [TICK_W-1:0] q_tick,
  input  wire cell_cmd_t                cmd,
  input  wire entry_t                   left_entry,
  input  wire entry_t                   right_entry,
  input  wire logic                     left_le,
  input  wire logic                     right_le,
  output entry_t                        entry,
  output cell_flags_t                   flags
);

  logic                     valid_r, valid_nxt;
  logic signed [TICK_W-1:0] tick_r, tick_nxt;
  logic        [TYPE_W-1:0] type_r, type_nxt;

  always_comb begin
    flags.le        = valid_r && (tick_r <= q_tick);
    flags.lt        = valid_r && (tick_r < q_tick);
    flags.eq        = valid_r && (tick_r == q_tick);
    flags.floor_hit = flags.le && !right_le;
    flags.ceil_hit  = valid_r && !flags.le && left_le;
  end

  always_comb begin
    valid_nxt = valid_r;
    tick_nxt  = tick_r;
    type_nxt  = type_r;
    if (cmd.insert && !flags.le) begin
      if (left_le) begin
        valid_nxt = 1'b1;
        tick_nxt  = cmd.new_tick;
        type_nxt  = cmd.new_type;
      end else begin
        valid_nxt = left_entry.valid;
        tick_nxt  = left_entry.tick;
        type_nxt  = left_entry.etype;
      end
    end else if (cmd.remove && !flags.lt) begin
      valid_nxt = right_entry.valid;
      tick_nxt  = right_entry.tick;
      type_nxt  = right_entry.etype;
    end else if (cmd.overwrite && flags.eq) begin
      type_nxt = cmd.new_type;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_r <= tick_nxt;
    type_r <= type_nxt;
  end

  assign entry.valid = valid_r;
  assign entry.tick  = tick_r;
  assign entry.etype = type_r;

endmodule

`default_nettype wire

// File: sv/timeline_change_point_table.sv
// ---------------------------------------------------------------------------
// timeline_change_point_table
// initial type plus a sorted chain of change points with lookup, edit and
// range queries
// ---------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  in_      in   in_tvalid/tready    in_tdata: action, tick, type_value
//  out_     out  out_tvalid/tready   out_tdata: type_out, range_start,
//                                    range_end, status
//  cfg_     in   cfg_valid/ready     cfg_data: default_type
//
//  each transaction: capture, then one compare pass over the chain
//  the compare pass and the chain shift close at the same edge
//  the next transaction is taken while a result waits in the output register
//  a stalled output holds the compare pass until the register frees
//  reset empties the chain, initial type back to zero
// ---------------------------------------------------------------------------
`default_nettype none

module timeline_change_point_table
  import tcpt_pkg::*;
#(
  parameter int TABLE_DEPTH = TCPT_TABLE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // action, tick, type_value, zero pad
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // type_out, range_start, range_end, status, pad
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [TYPE_W-1:0]     cfg_data    // default_type
);

  `include "timeline_change_point_table_macros.svh"

  tcpt_state_t              state_r, state_nxt;
  tcpt_action_t             q_action_r;
  logic signed [TICK_W-1:0] q_tick_r;
  logic        [TYPE_W-1:0] q_type_r;
  logic        [TYPE_W-1:0] default_type_r;
  logic        [TYPE_W-1:0] initial_type_r, initial_type_nxt;
  logic                     out_valid_r;
  logic [OUT_FIELDS_W-1:0]  out_fields_r;

  entry_t      cell_entry [TABLE_DEPTH];
  cell_flags_t cell_flags [TABLE_DEPTH];
  cell_cmd_t   cmd;

  logic                     advance;
  logic                     in_accept;
  logic [TABLE_DEPTH-1:0]   valid_vec, floor_vec;
  logic                     any_floor, any_ceil, any_eq, full;
  logic signed [TICK_W-1:0] floor_tick, ceil_tick;
  logic        [TYPE_W-1:0] floor_type;
  logic                     neg, zero;

  logic        [TYPE_W-1:0] res_type;
  logic signed [TICK_W-1:0] res_start, res_end;
  tcpt_status_t             res_status;

  // chain of cells
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    entry_t l_entry, r_entry;
    logic   l_le, r_le;
    if (k == 0) begin : g_first
      assign l_entry = '0;
      assign l_le    = 1'b1;
    end else begin : g_mid_l
      assign l_entry = cell_entry[k-1];
      assign l_le    = cell_flags[k-1].le;
    end
    if (k == TABLE_DEPTH - 1) begin : g_last
      assign r_entry = '0;
      assign r_le    = 1'b0;
    end else begin : g_mid_r
      assign r_entry = cell_entry[k+1];
      assign r_le    = cell_flags[k+1].le;
    end
    tcpt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .q_tick      (q_tick_r),
      .cmd         (cmd),
      .left_entry  (l_entry),
      .right_entry (r_entry),
      .left_le     (l_le),
      .right_le    (r_le),
      .entry       (cell_entry[k]),
      .flags       (cell_flags[k])
    );
  end

  // one-hot gather of the hit cells
  always_comb begin
    valid_vec  = '0;
    floor_vec  = '0;
    any_floor  = 1'b0;
    any_ceil   = 1'b0;
    any_eq     = 1'b0;
    floor_tick = '0;
    floor_type = '0;
    ceil_tick  = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      valid_vec[k] = cell_entry[k].valid;
      floor_vec[k] = cell_flags[k].floor_hit;
      any_floor    = any_floor | cell_flags[k].floor_hit;
      any_ceil     = any_ceil | cell_flags[k].ceil_hit;
      any_eq       = any_eq | cell_flags[k].eq;
      floor_tick   = floor_tick | (cell_entry[k].tick & {TICK_W{cell_flags[k].floor_hit}});
      floor_type   = floor_type | (cell_entry[k].etype & {TYPE_W{cell_flags[k].floor_hit}});
      ceil_tick    = ceil_tick | (cell_entry[k].tick & {TICK_W{cell_flags[k].ceil_hit}});
    end
    full = cell_entry[TABLE_DEPTH-1].valid;
  end

  assign neg       = q_tick_r[TICK_W-1];
  assign zero      = (q_tick_r == '0);
  assign advance   = (state_r == ST_BUSY) && (!out_valid_r || out_tready);
  assign in_accept = in_tvalid && in_tready;

  // result and chain command
  always_comb begin
    res_type         = '0;
    res_start        = '0;
    res_end          = '0;
    res_status       = STS_OK;
    initial_type_nxt = initial_type_r;
    cmd              = '0;
    cmd.new_tick     = q_tick_r;
    cmd.new_type     = q_type_r;
    case (q_action_r)
      ACT_LOOKUP: begin
        if (neg) begin
          res_type = default_type_r;
        end else if (any_floor) begin
          res_type = floor_type;
        end else begin
          res_type = initial_type_r;
        end
      end
      ACT_SET: begin
        if (neg) begin
          res_status = STS_NEGATIVE;
        end else if (zero) begin
          initial_type_nxt = q_type_r;
          res_type         = q_type_r;
        end else if (any_eq) begin
          cmd.overwrite = advance;
          res_type      = q_type_r;
        end else if (full) begin
          res_status = STS_FULL;
        end else begin
          cmd.insert = advance;
          res_type   = q_type_r;
        end
      end
      ACT_REMOVE: begin
        if (neg) begin
          res_status = STS_NEGATIVE;
        end else if (zero) begin
          initial_type_nxt = default_type_r;
        end else if (any_eq) begin
          cmd.remove = advance;
        end else begin
          res_status = STS_NOT_FOUND;
        end
      end
      default: begin
        if (neg) begin
          res_start = '1;
          res_end   = '1;
        end else begin
          res_start = any_floor ? floor_tick : '0;
          res_end   = any_ceil ? ceil_tick : '1;
        end
      end
    endcase
  end

  // control
  always_comb begin
    state_nxt = state_r;
    in_tready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (advance) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      default_type_r <= DEFAULT_TYPE_RST;
      initial_type_r <= DEFAULT_TYPE_RST;
    end else begin
      if (advance) begin
        out_valid_r    <= 1'b1;
        initial_type_r <= initial_type_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        default_type_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_action_r <= tcpt_action_t'(in_tdata[ACTION_W-1:0]);
      q_tick_r   <= in_tdata[ACTION_W +: TICK_W];
      q_type_r   <= in_tdata[ACTION_W+TICK_W +: TYPE_W];
    end
    if (advance) begin
      out_fields_r <= {res_status, res_end, res_start, res_type};
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_fields_r);

  `TCPT_ASSERT(a_accept_busy, clk, rst_n, in_accept |=> (state_r == ST_BUSY), "accept did not start a compare pass")
  `TCPT_ASSERT(a_chain_packed, clk, rst_n, (valid_vec & (valid_vec + TABLE_DEPTH'(1))) == '0, "chain has a hole")
  `TCPT_ASSERT(a_floor_onehot, clk, rst_n, $onehot0(floor_vec), "more than one floor cell")
  `TCPT_ASSERT(a_advance_result, clk, rst_n, advance |=> out_valid_r, "compare pass lost its result")
  `TCPT_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "reset left control busy")

endmodule

`default_nettype wire
